### rtl/bfc_pkg.sv
// Shared types and constants for the bidirectional flow counter.
// Holds the table geometry, the flow key and statistics records and the outcome codes.
// Depends on nothing; bfc_search and the top level use it.
package bfc_pkg;

	// Table geometry.
	localparam int TABLE_ENTRIES = 256;
	localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int COUNT_W       = $clog2(TABLE_ENTRIES + 1);

	// Header sizes used by the length checks.
	localparam logic [16:0] ETH_HDR_BYTES    = 17'd14;
	localparam logic [16:0] IP_STRUCT_BYTES  = 17'd20;
	localparam logic [16:0] TCP_STRUCT_BYTES = 17'd20;
	localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;

	// Result outcome codes.
	typedef enum logic [2:0] {
		OUT_NONE = 3'd0,
		OUT_FWD  = 3'd1,
		OUT_REV  = 3'd2,
		OUT_NEW  = 3'd3,
		OUT_FULL = 3'd4
	} outcome_t;

	// Flow key as it is kept in the key memory.
	typedef struct packed {
		logic [63:0] addrs;
		logic [31:0] ports;
		logic [7:0]  proto;
	} flow_key_t;

	// Per-flow statistics as kept in the statistics memory.
	typedef struct packed {
		logic [31:0] packets;
		logic [31:0] bytes;
		logic [31:0] last_seen;
	} flow_stat_t;

	// Search progress reported by the key scanner.
	typedef struct packed {
		logic              fwd_hit;
		logic [SLOT_W-1:0] fwd_slot;
		logic              rev_hit;
		logic [SLOT_W-1:0] rev_slot;
	} search_status_t;

	localparam int KEY_W  = $bits(flow_key_t);
	localparam int STAT_W = $bits(flow_stat_t);

endpackage

### rtl/bfc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
module bfc_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the read data is registered and appears in the cycle after rd_en.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/bfc_search.sv
// Key scanner: compares each entry read from the key memory with the forward and
// reverse keys and keeps the first slot that matches each. Depends on bfc_pkg.
module bfc_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic                        data_valid,
	input  logic [bfc_pkg::SLOT_W-1:0]  data_slot,
	input  bfc_pkg::flow_key_t          data_key,
	input  bfc_pkg::flow_key_t          fwd_key,
	input  bfc_pkg::flow_key_t          rev_key,
	output bfc_pkg::search_status_t     status
);

	bfc_pkg::search_status_t status_q;
	logic fwd_match;
	logic rev_match;

	// Compare the entry that just came out of the memory.
	assign fwd_match = data_valid && (data_key == fwd_key);
	assign rev_match = data_valid && (data_key == rev_key);

	// Keep the lowest matching slot in each direction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
		end else if (clear) begin
			status_q <= '0;
		end else begin
			if (fwd_match && !status_q.fwd_hit) begin
				status_q.fwd_hit  <= 1'b1;
				status_q.fwd_slot <= data_slot;
			end
			if (rev_match && !status_q.rev_hit) begin
				status_q.rev_hit  <= 1'b1;
				status_q.rev_slot <= data_slot;
			end
		end
	end

	assign status = status_q;

endmodule

### rtl/bidirectional_flow_counter_unit.sv
// Top level of the bidirectional flow counter: length checks, table sequencer,
// key and statistics memories. Depends on bfc_pkg, bfc_ram and bfc_search.
//
// Usage: one packet summary is taken per input transfer (in_valid high and
// in_stall low) and exactly one result leaves per output transfer (out_valid
// high and out_stall low). in_stall is high while an item is being worked on.
// Packets that are dropped or are not IPv4 go from idle straight to the finish
// step and skip the scan. An IPv4 packet scans the key memory one slot per
// cycle over the n slots in use (up to TABLE_ENTRIES); a forward hit ends the
// scan early. It then passes the resolve step, on a hit a read-modify-write
// step, and the finish step. Slots fill from the lowest index and are never
// freed, so a fill count marks the valid slots: reset empties the table at
// once and no clearing pass is needed. The result sits in an output register;
// while the receiver stalls it is held, the next item may still be taken and
// worked on, and its result waits until the held one has been transferred.
module bidirectional_flow_counter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] packet_length,
	input  logic [15:0] ether_type,
	input  logic [3:0]  header_words,
	input  logic [7:0]  ip_protocol,
	input  logic [31:0] source_address,
	input  logic [31:0] dest_address,
	input  logic [15:0] source_port,
	input  logic [15:0] dest_port,
	input  logic [31:0] now_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        verdict,
	output logic [2:0]  outcome,
	output logic [7:0]  slot_index,
	output logic [31:0] flow_packets,
	output logic [31:0] flow_bytes
);

	localparam int SLOT_W  = bfc_pkg::SLOT_W;
	localparam int COUNT_W = bfc_pkg::COUNT_W;
	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(bfc_pkg::TABLE_ENTRIES);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_SCAN    = 5'b00010,
		ST_RESOLVE = 5'b00100,
		ST_RMW     = 5'b01000,
		ST_FINISH  = 5'b10000
	} state_t;

	state_t state_q;

	// Item registers.
	logic [15:0]             len_q;
	logic [31:0]             now_q;
	bfc_pkg::flow_key_t      fwd_key_q;
	bfc_pkg::flow_key_t      rev_key_q;
	logic [COUNT_W-1:0]      count_q;
	logic [COUNT_W-1:0]      issue_q;
	logic                    rd_vld_s1;
	logic [SLOT_W-1:0]       rd_slot_s1;
	logic [SLOT_W-1:0]       hit_slot_q;

	// Result being built and the output register.
	logic                    res_verdict_q;
	bfc_pkg::outcome_t       res_outcome_q;
	logic [SLOT_W-1:0]       res_slot_q;
	logic [31:0]             res_packets_q;
	logic [31:0]             res_bytes_q;
	logic                    out_valid_q;
	logic                    out_verdict_q;
	logic [2:0]              out_outcome_q;
	logic [7:0]              out_slot_q;
	logic [31:0]             out_packets_q;
	logic [31:0]             out_bytes_q;

	// Memory and scanner connections.
	logic                    key_rd_en;
	bfc_pkg::flow_key_t      key_rd_data;
	logic                    key_wr_en;
	logic                    stat_rd_en;
	logic                    stat_wr_en;
	logic [SLOT_W-1:0]       stat_wr_addr;
	bfc_pkg::flow_stat_t     stat_wr_data;
	bfc_pkg::flow_stat_t     stat_rd_data;
	bfc_pkg::search_status_t search;

	logic                    in_xfer;
	logic                    out_xfer;
	logic                    is_short;
	logic                    is_ipv4;
	logic                    hdr_short;
	logic                    scan_done;
	logic                    load_out;
	logic [16:0]             need_bytes;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign load_out = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	// Length and type checks on the incoming summary.
	assign need_bytes = bfc_pkg::ETH_HDR_BYTES + {11'd0, header_words, 2'b00}
		+ bfc_pkg::TCP_STRUCT_BYTES;
	assign is_short  = {1'b0, packet_length} < bfc_pkg::ETH_HDR_BYTES;
	assign is_ipv4   = (ether_type == bfc_pkg::ETHERTYPE_IPV4);
	assign hdr_short = ({1'b0, packet_length} <
		(bfc_pkg::ETH_HDR_BYTES + bfc_pkg::IP_STRUCT_BYTES))
		|| ({1'b0, packet_length} < need_bytes);

	// Scan reads slots in use until all are seen or a forward hit appears.
	assign key_rd_en = (state_q == ST_SCAN) && (issue_q < count_q) && !search.fwd_hit;
	assign scan_done = search.fwd_hit || (!key_rd_en && !rd_vld_s1);

	assign key_wr_en = (state_q == ST_RESOLVE) && !search.fwd_hit && !search.rev_hit
		&& (count_q != FULL_COUNT);
	assign stat_rd_en = (state_q == ST_RESOLVE) && (search.fwd_hit || search.rev_hit);

	// Statistics write: fresh entry on insert, updated entry after the read.
	always_comb begin
		stat_wr_en   = 1'b0;
		stat_wr_addr = count_q[SLOT_W-1:0];
		stat_wr_data = '{packets: 32'd1, bytes: {16'd0, len_q}, last_seen: now_q};
		if (key_wr_en) begin
			stat_wr_en = 1'b1;
		end else if (state_q == ST_RMW) begin
			stat_wr_en   = 1'b1;
			stat_wr_addr = hit_slot_q;
			stat_wr_data = '{packets: stat_rd_data.packets + 32'd1,
				bytes: stat_rd_data.bytes + {16'd0, len_q}, last_seen: now_q};
		end
	end

	bfc_ram #(.WIDTH(bfc_pkg::KEY_W), .DEPTH(bfc_pkg::TABLE_ENTRIES)) u_key_ram (
		.clk     (clk),
		.wr_en   (key_wr_en),
		.wr_addr (count_q[SLOT_W-1:0]),
		.wr_data (fwd_key_q),
		.rd_en   (key_rd_en),
		.rd_addr (issue_q[SLOT_W-1:0]),
		.rd_data (key_rd_data)
	);

	bfc_ram #(.WIDTH(bfc_pkg::STAT_W), .DEPTH(bfc_pkg::TABLE_ENTRIES)) u_stat_ram (
		.clk     (clk),
		.wr_en   (stat_wr_en),
		.wr_addr (stat_wr_addr),
		.wr_data (stat_wr_data),
		.rd_en   (stat_rd_en),
		.rd_addr (search.fwd_hit ? search.fwd_slot : search.rev_slot),
		.rd_data (stat_rd_data)
	);

	bfc_search u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (in_xfer),
		.data_valid (rd_vld_s1),
		.data_slot  (rd_slot_s1),
		.data_key   (key_rd_data),
		.fwd_key    (fwd_key_q),
		.rev_key    (rev_key_q),
		.status     (search)
	);

	// Read tracking for the key scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= key_rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_slot_s1 <= issue_q[SLOT_W-1:0];
	end

	// Sequencer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			issue_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						issue_q <= '0;
						if (is_short || !is_ipv4 || hdr_short) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (key_rd_en) begin
						issue_q <= issue_q + COUNT_W'(1);
					end
					if (scan_done) begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (stat_rd_en) begin
						state_q <= ST_RMW;
					end else begin
						state_q <= ST_FINISH;
					end
					if (key_wr_en) begin
						count_q <= count_q + COUNT_W'(1);
					end
				end
				ST_RMW: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item capture and result assembly.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			len_q     <= packet_length;
			now_q     <= now_time;
			fwd_key_q <= '{addrs: {source_address, dest_address},
				ports: {source_port, dest_port}, proto: ip_protocol};
			rev_key_q <= '{addrs: {dest_address, source_address},
				ports: {dest_port, source_port}, proto: ip_protocol};
			res_verdict_q <= is_short || (is_ipv4 && hdr_short);
			res_outcome_q <= bfc_pkg::OUT_NONE;
			res_slot_q    <= '0;
			res_packets_q <= '0;
			res_bytes_q   <= '0;
		end
		if (state_q == ST_RESOLVE) begin
			if (search.fwd_hit) begin
				res_outcome_q <= bfc_pkg::OUT_FWD;
				hit_slot_q    <= search.fwd_slot;
			end else if (search.rev_hit) begin
				res_outcome_q <= bfc_pkg::OUT_REV;
				hit_slot_q    <= search.rev_slot;
			end else if (count_q == FULL_COUNT) begin
				res_outcome_q <= bfc_pkg::OUT_FULL;
			end else begin
				res_outcome_q <= bfc_pkg::OUT_NEW;
				res_slot_q    <= count_q[SLOT_W-1:0];
				res_packets_q <= 32'd1;
				res_bytes_q   <= {16'd0, len_q};
			end
		end
		if (state_q == ST_RMW) begin
			res_slot_q    <= hit_slot_q;
			res_packets_q <= stat_wr_data.packets;
			res_bytes_q   <= stat_wr_data.bytes;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_verdict_q <= res_verdict_q;
			out_outcome_q <= res_outcome_q;
			out_slot_q    <= 8'(res_slot_q);
			out_packets_q <= res_packets_q;
			out_bytes_q   <= res_bytes_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign verdict      = out_verdict_q;
	assign outcome      = out_outcome_q;
	assign slot_index   = out_slot_q;
	assign flow_packets = out_packets_q;
	assign flow_bytes   = out_bytes_q;

`ifndef SYNTH
	// An accepted item blocks the input until its work is done.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input not stalled after transfer");

	// A new result appears only out of the finish step.
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FINISH))
		else $error("result without finish step");

	// Reported forward hits always point at slots in use.
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		search.fwd_hit |-> ({1'b0, search.fwd_slot} < count_q))
		else $error("forward hit beyond fill count");

	// An insert grows the fill count by exactly one.
	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		key_wr_en |=> (count_q == $past(count_q) + COUNT_W'(1)))
		else $error("fill count not advanced on insert");
`endif

endmodule
